FILE: design/keyframe_light_fader_core_macros.svh
// ----------------------------------------------------------------------------
// Keyframe light fader assertion macros
// Shared property wrappers for the fader's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_LIGHT_FADER_CORE_MACROS_SVH
`define KEYFRAME_LIGHT_FADER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define KFLF_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("kflf check failed");

// Next-cycle implication, disabled during reset.
`define KFLF_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("kflf check failed");

`endif

FILE: design/kflf_pkg.sv
// ----------------------------------------------------------------------------
// Keyframe light fader package
// Shared types, codes and default sizes of the keyframe light fader.
// ----------------------------------------------------------------------------
package kflf_pkg;

   localparam int MAX_KEYS_DEF      = 16;
   localparam int FRACTION_BITS_DEF = 8;

   localparam int TIME_W      = 24;
   localparam int KEY_COUNT_W = 5;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 5;

   // item kinds
   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_LOOP_ENABLE        = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTERPOLATE_ENABLE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_COUNT          = 2'd2;

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [15:0] intensity;
      logic [15:0] spec_intensity;
      logic [7:0]  corona_alpha;
   } light_value_type;

   typedef struct packed {
      logic [15:0]     duration;
      light_value_type value;
   } key_entry_type;

   typedef struct packed {
      logic load;
      logic accum;
   } mac_ctl_type;

endpackage

FILE: design/kflf_mac.sv
// ----------------------------------------------------------------------------
// Keyframe light fader multiply-accumulate unit
// One multiplier and accumulator, shared by every blended channel.
// ----------------------------------------------------------------------------
module kflf_mac
   import kflf_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                      clock,
   input  mac_ctl_type               mac_ctl,
   input  logic [15:0]               op_value,
   input  logic [FRACTION_BITS:0]    op_weight,
   output logic [FRACTION_BITS+16:0] acc
);

   localparam int ACC_W = FRACTION_BITS + 17;
   localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (FRACTION_BITS - 1);

   logic [ACC_W-1:0] prod;
   logic [ACC_W-1:0] acc_ff;
   logic [ACC_W-1:0] acc_in;

   assign prod = ACC_W'(op_value) * ACC_W'(op_weight);

   always_comb begin
      acc_in = acc_ff;
      if (mac_ctl.load) begin
         acc_in = prod + HALF;
      end else if (mac_ctl.accum) begin
         acc_in = acc_ff + prod;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

FILE: design/keyframe_light_fader_core.sv
// ----------------------------------------------------------------------------
// Keyframe light fader core
// Keyframe table with animation time, span search, fraction divide and blend.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item: a keyframe write (stored at key_index) or a time
//   tick (delta_ticks added to the animation time). Each item gives exactly
//   one rsp_* item: current light values, segment, Q0.8 fraction and a
//   segment_found flag. csr_* writes loop_enable, interpolate_enable and
//   key_count; the user must write them only while the block is idle, as
//   the block itself does not enforce it. The table is a single-port
//   memory with a registered read, so each step of the sum and search
//   walks has a read state and a use state; the divide takes one quotient
//   bit a cycle and the blend runs seven channels through one
//   multiply-accumulate unit, in load, accumulate and write states each.
//   One item is in work at a time: req_stall is high from acceptance until
//   the result is loaded into the output register.
//   Reset clears time, held values, key_count, interpolate_enable and
//   handshake state, and sets loop_enable. Table entries are undefined
//   until written. A stalled result holds in the output register; the next
//   item may be accepted meanwhile and waits at its end till the register frees.
// ----------------------------------------------------------------------------
`include "keyframe_light_fader_core_macros.svh"

module keyframe_light_fader_core
   import kflf_pkg::*;
#(
   parameter int MAX_KEYS      = MAX_KEYS_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // configuration
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   // input items
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_kind,
   input  logic [15:0]            req_delta_ticks,
   input  logic [3:0]             req_key_index,
   input  logic [15:0]            req_key_duration,
   input  logic [7:0]             req_key_red,
   input  logic [7:0]             req_key_green,
   input  logic [7:0]             req_key_blue,
   input  logic [7:0]             req_key_alpha,
   input  logic [15:0]            req_key_intensity,
   input  logic [15:0]            req_key_spec_intensity,
   input  logic [7:0]             req_key_corona_alpha,
   // result items
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_red,
   output logic [7:0]             rsp_out_green,
   output logic [7:0]             rsp_out_blue,
   output logic [7:0]             rsp_out_alpha,
   output logic [15:0]            rsp_out_intensity,
   output logic [15:0]            rsp_out_spec_intensity,
   output logic [7:0]             rsp_out_corona_alpha,
   output logic [3:0]             rsp_segment,
   output logic [7:0]             rsp_fraction,
   output logic                   rsp_segment_found
);

   localparam int AW    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int FW    = FRACTION_BITS;
   localparam int ACC_W = FW + 17;
   localparam int DCW   = $clog2(FW + 1);
   localparam int SH_R  = (FW >= 8) ? (FW - 8) : 0;
   localparam int SH_L  = (FW < 8) ? (8 - FW) : 0;
   localparam logic [FW:0] ONE_Q = {1'b1, {FW{1'b0}}};

   // blend channel order
   localparam logic [2:0] CH_RED       = 3'd0;
   localparam logic [2:0] CH_GREEN     = 3'd1;
   localparam logic [2:0] CH_BLUE      = 3'd2;
   localparam logic [2:0] CH_ALPHA     = 3'd3;
   localparam logic [2:0] CH_INTENSITY = 3'd4;
   localparam logic [2:0] CH_SPEC      = 3'd5;
   localparam logic [2:0] CH_CORONA    = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUM_RD,
      ST_SUM_ACC,
      ST_TIME_UPD,
      ST_SRCH_RD,
      ST_SRCH_CHK,
      ST_DIVIDE,
      ST_CUR_RD,
      ST_CUR_LD,
      ST_NXT_RD,
      ST_NXT_LD,
      ST_BL_LOAD,
      ST_BL_ACC,
      ST_BL_WR,
      ST_FINISH
   } state_type;

   // keyframe table
   key_entry_type key_mem [MAX_KEYS];
   key_entry_type rd_entry_ff;
   key_entry_type wr_entry;

   // control state
   state_type                state_ff;
   logic                     loop_en_ff;
   logic                     interp_en_ff;
   logic [KEY_COUNT_W-1:0]   key_count_ff;
   logic [TIME_W-1:0]        anim_ff;
   light_value_type          held_ff;
   logic                     rsp_valid_ff;
   logic [KEY_COUNT_W-1:0]   idx_ff;
   logic [DCW-1:0]           div_cnt_ff;
   logic [2:0]               ch_ff;

   // working payload
   logic [15:0]              delta_ff;
   logic [TIME_W-1:0]        acc_ff;
   logic [KEY_COUNT_W-1:0]   found_idx_ff;
   logic                     found_ff;
   logic [15:0]              dur_ff;
   logic [16:0]              rem_ff;
   logic [FW-1:0]            f_ff;
   light_value_type          cur_ff;
   light_value_type          nxt_ff;

   // output register
   light_value_type          rsp_val_ff;
   logic [3:0]               rsp_seg_ff;
   logic [7:0]               rsp_frac_ff;
   logic                     rsp_found_ff;

   // datapath
   logic                     req_accept;
   logic                     rsp_load;
   logic                     key_in_range;
   logic [KEY_COUNT_W-1:0]   n_keys;
   logic [KEY_COUNT_W-1:0]   idx_next;
   logic [KEY_COUNT_W-1:0]   nxt_idx;
   logic [TIME_W-1:0]        sum_next;
   logic [TIME_W:0]          t_sum;
   logic [TIME_W-1:0]        t_new;
   logic [16:0]              rem_shift;
   logic                     rem_ge;
   logic [16:0]              rem_sub;
   logic [15:0]              frac16;
   logic [7:0]               frac_q8;
   mac_ctl_type              mac_ctl;
   logic [15:0]              mac_value;
   logic [FW:0]              mac_weight;
   logic [ACC_W-1:0]         mac_acc;

   assign req_accept   = req_valid && !req_stall;
   assign req_stall    = (state_ff != ST_IDLE);
   assign key_in_range = (32'(req_key_index) < MAX_KEYS);

   // load the output register once it is empty or being taken
   assign rsp_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   assign wr_entry.duration             = req_key_duration;
   assign wr_entry.value.red            = req_key_red;
   assign wr_entry.value.green          = req_key_green;
   assign wr_entry.value.blue           = req_key_blue;
   assign wr_entry.value.alpha          = req_key_alpha;
   assign wr_entry.value.intensity      = req_key_intensity;
   assign wr_entry.value.spec_intensity = req_key_spec_intensity;
   assign wr_entry.value.corona_alpha   = req_key_corona_alpha;

   // clamp the key count to the table depth
   assign n_keys   = (32'(key_count_ff) > MAX_KEYS) ? KEY_COUNT_W'(MAX_KEYS) : key_count_ff;
   assign idx_next = idx_ff + KEY_COUNT_W'(1);
   assign nxt_idx  = (idx_next < n_keys) ? idx_next : '0;

   // shared adder for the duration sum and the span search
   assign sum_next = acc_ff + TIME_W'(rd_entry_ff.duration);

   // advance time: wrap under loop, otherwise saturate
   assign t_sum = {1'b0, anim_ff} + (TIME_W + 1)'(delta_ff);
   always_comb begin
      if (loop_en_ff && (t_sum >= (TIME_W + 1)'(acc_ff))) begin
         t_new = '0;
      end else if (t_sum[TIME_W]) begin
         t_new = '1;
      end else begin
         t_new = t_sum[TIME_W-1:0];
      end
   end

   // restoring divide, one quotient bit per cycle
   assign rem_shift = {rem_ff[15:0], 1'b0};
   assign rem_ge    = (rem_shift >= {1'b0, dur_ff});
   assign rem_sub   = rem_shift - {1'b0, dur_ff};

   // move the fraction to Q0.8
   assign frac16  = 16'(f_ff);
   assign frac_q8 = (FW >= 8) ? 8'(frac16 >> SH_R) : 8'(frac16 << SH_L);

   // blend operands: current value times (1 - f), then next value times f
   always_comb begin
      mac_ctl.load  = (state_ff == ST_BL_LOAD);
      mac_ctl.accum = (state_ff == ST_BL_ACC);
      mac_weight    = mac_ctl.load ? (ONE_Q - {1'b0, f_ff}) : {1'b0, f_ff};
      case (ch_ff)
         CH_RED: begin
            mac_value = mac_ctl.load ? 16'(cur_ff.red) : 16'(nxt_ff.red);
         end
         CH_GREEN: begin
            mac_value = mac_ctl.load ? 16'(cur_ff.green) : 16'(nxt_ff.green);
         end
         CH_BLUE: begin
            mac_value = mac_ctl.load ? 16'(cur_ff.blue) : 16'(nxt_ff.blue);
         end
         CH_ALPHA: begin
            mac_value = mac_ctl.load ? 16'(cur_ff.alpha) : 16'(nxt_ff.alpha);
         end
         CH_INTENSITY: begin
            mac_value = mac_ctl.load ? cur_ff.intensity : nxt_ff.intensity;
         end
         CH_SPEC: begin
            mac_value = mac_ctl.load ? cur_ff.spec_intensity : nxt_ff.spec_intensity;
         end
         CH_CORONA: begin
            mac_value = mac_ctl.load ? 16'(cur_ff.corona_alpha) : 16'(nxt_ff.corona_alpha);
         end
         default: begin
            mac_value = '0;
         end
      endcase
   end

   kflf_mac #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_mac (
      .clock    (clock),
      .mac_ctl  (mac_ctl),
      .op_value (mac_value),
      .op_weight(mac_weight),
      .acc      (mac_acc)
   );

   // table: one write port, one registered read port at the walk index
   always_ff @(posedge clock) begin
      if (req_accept && (req_kind == KIND_WRITE) && key_in_range) begin
         key_mem[AW'(req_key_index)] <= wr_entry;
      end
      rd_entry_ff <= key_mem[AW'(idx_ff)];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         loop_en_ff   <= 1'b1;
         interp_en_ff <= 1'b0;
         key_count_ff <= '0;
         anim_ff      <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         div_cnt_ff   <= '0;
         ch_ff        <= CH_RED;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_LOOP_ENABLE:        loop_en_ff   <= csr_wdata[0];
               CSR_INTERPOLATE_ENABLE: interp_en_ff <= csr_wdata[0];
               CSR_KEY_COUNT:          key_count_ff <= csr_wdata[KEY_COUNT_W-1:0];
               default: ;
            endcase
         end

         // raise valid on a new result, drop it once the receiver takes it
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  delta_ff     <= req_delta_ticks;
                  acc_ff       <= '0;
                  idx_ff       <= '0;
                  found_idx_ff <= '0;
                  found_ff     <= 1'b0;
                  f_ff         <= '0;
                  if (req_kind == KIND_WRITE) begin
                     state_ff <= ST_FINISH;
                  end else if (n_keys == '0) begin
                     state_ff <= ST_TIME_UPD;
                  end else begin
                     state_ff <= ST_SUM_RD;
                  end
               end
            end
            ST_SUM_RD: begin
               state_ff <= ST_SUM_ACC;
            end
            ST_SUM_ACC: begin
               acc_ff <= sum_next;
               if (idx_next == n_keys) begin
                  idx_ff   <= '0;
                  state_ff <= ST_TIME_UPD;
               end else begin
                  idx_ff   <= idx_next;
                  state_ff <= ST_SUM_RD;
               end
            end
            ST_TIME_UPD: begin
               anim_ff <= t_new;
               acc_ff  <= '0;
               idx_ff  <= '0;
               if (n_keys == '0) begin
                  state_ff <= ST_FINISH;
               end else begin
                  state_ff <= ST_SRCH_RD;
               end
            end
            ST_SRCH_RD: begin
               state_ff <= ST_SRCH_CHK;
            end
            ST_SRCH_CHK: begin
               if (sum_next > anim_ff) begin
                  // span found: remainder starts at the offset into the span
                  found_ff     <= 1'b1;
                  found_idx_ff <= idx_ff;
                  dur_ff       <= rd_entry_ff.duration;
                  rem_ff       <= {1'b0, 16'(anim_ff - acc_ff)};
                  div_cnt_ff   <= DCW'(FW);
                  state_ff     <= ST_DIVIDE;
               end else if (idx_next == n_keys) begin
                  state_ff <= ST_FINISH;
               end else begin
                  acc_ff   <= sum_next;
                  idx_ff   <= idx_next;
                  state_ff <= ST_SRCH_RD;
               end
            end
            ST_DIVIDE: begin
               f_ff   <= {f_ff[FW-2:0], rem_ge};
               rem_ff <= rem_ge ? rem_sub : rem_shift;
               if (div_cnt_ff == DCW'(1)) begin
                  state_ff <= ST_CUR_RD;
               end else begin
                  div_cnt_ff <= div_cnt_ff - DCW'(1);
               end
            end
            ST_CUR_RD: begin
               state_ff <= ST_CUR_LD;
            end
            ST_CUR_LD: begin
               if (interp_en_ff) begin
                  cur_ff   <= rd_entry_ff.value;
                  idx_ff   <= nxt_idx;
                  state_ff <= ST_NXT_RD;
               end else begin
                  held_ff  <= rd_entry_ff.value;
                  state_ff <= ST_FINISH;
               end
            end
            ST_NXT_RD: begin
               state_ff <= ST_NXT_LD;
            end
            ST_NXT_LD: begin
               nxt_ff   <= rd_entry_ff.value;
               ch_ff    <= CH_RED;
               state_ff <= ST_BL_LOAD;
            end
            ST_BL_LOAD: begin
               state_ff <= ST_BL_ACC;
            end
            ST_BL_ACC: begin
               state_ff <= ST_BL_WR;
            end
            ST_BL_WR: begin
               case (ch_ff)
                  CH_RED:       held_ff.red            <= mac_acc[FW +: 8];
                  CH_GREEN:     held_ff.green          <= mac_acc[FW +: 8];
                  CH_BLUE:      held_ff.blue           <= mac_acc[FW +: 8];
                  CH_ALPHA:     held_ff.alpha          <= mac_acc[FW +: 8];
                  CH_INTENSITY: held_ff.intensity      <= mac_acc[FW +: 16];
                  CH_SPEC:      held_ff.spec_intensity <= mac_acc[FW +: 16];
                  CH_CORONA:    held_ff.corona_alpha   <= mac_acc[FW +: 8];
                  default: ;
               endcase
               if (ch_ff == CH_CORONA) begin
                  state_ff <= ST_FINISH;
               end else begin
                  ch_ff    <= ch_ff + 3'd1;
                  state_ff <= ST_BL_LOAD;
               end
            end
            ST_FINISH: begin
               // hold until the output register is free
               if (rsp_load) begin
                  rsp_val_ff   <= held_ff;
                  rsp_seg_ff   <= 4'(found_idx_ff);
                  rsp_frac_ff  <= frac_q8;
                  rsp_found_ff <= found_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_out_red            = rsp_val_ff.red;
   assign rsp_out_green          = rsp_val_ff.green;
   assign rsp_out_blue           = rsp_val_ff.blue;
   assign rsp_out_alpha          = rsp_val_ff.alpha;
   assign rsp_out_intensity      = rsp_val_ff.intensity;
   assign rsp_out_spec_intensity = rsp_val_ff.spec_intensity;
   assign rsp_out_corona_alpha   = rsp_val_ff.corona_alpha;
   assign rsp_segment            = rsp_seg_ff;
   assign rsp_fraction           = rsp_frac_ff;
   assign rsp_segment_found      = rsp_found_ff;

   // an accepted item always leaves idle in the next cycle
   `KFLF_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_accept, state_ff != ST_IDLE)
   // the divide remainder stays below the span duration
   `KFLF_ASSERT_NOW(a_div_rem_bound, clock, reset, state_ff == ST_DIVIDE, rem_ff < {1'b0, dur_ff})
   // an unmatched result carries segment and fraction zero
   `KFLF_ASSERT_NOW(a_unmatched_zero, clock, reset, rsp_valid_ff && !rsp_found_ff, (rsp_seg_ff == 4'd0) && (rsp_frac_ff == 8'd0))

endmodule
